// ===== src/psrs_pkg.sv =====
package psrs_pkg;

    localparam int SLOT_COUNT_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 32;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  slot;
        logic [31:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  slot_out;
        logic [31:0] current_time;
        logic [31:0] mean_time;
        logic [31:0] std_dev;
        logic [31:0] max_time;
        logic [31:0] sample_count;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input, issue memory read
        logic clr_start;  // begin clear sweep at entry 0
        logic clr_step;   // write zero to sweep entry, advance
        logic upd;        // compute count/max/mean-abs diff
        logic div_start;  // begin mean step division
        logic div_step;
        logic mean_fin;   // form new mean and deviation product operands
        logic mul_step;   // multiply partial
        logic q_fin;      // add to Q, write back
        logic vdiv_start; // begin Q/(n-1)
        logic vdiv_step;
        logic sqrt_start;
        logic sqrt_step;
        logic res_fin;    // form output item
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_clear;
        logic in_range;
        logic clr_last;
        logic n_gt1;
    } stat_t;

endpackage

// ===== src/psrs_ctrl.sv =====
module psrs_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  psrs_pkg::stat_t st,
    output psrs_pkg::cmd_t  cmd
);
    import psrs_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD, S_DEC, S_CLR, S_UPD, S_DIV, S_MEAN, S_MUL, S_Q,
        S_VDIV, S_SQRT, S_FIN
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic       ov_reg, ov_next;

    assign out_valid = ov_reg;
    assign in_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_INIT:
            begin
                cmd.clr_start = 1'b1;
                state_next    = S_CLR;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (st.is_clear)
                begin
                    cmd.clr_start = 1'b1;
                    state_next    = S_CLR;
                end
                else if (st.in_range)
                begin
                    state_next = S_UPD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_DIV;
                cnt_next   = 7'd0;
            end
            S_DIV:
            begin
                if (cnt_reg == 7'd0)
                begin
                    cmd.div_start = 1'b1;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd33)
                begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                cmd.mean_fin = 1'b1;
                cnt_next     = 7'd0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    state_next = S_Q;
                end
            end
            S_Q:
            begin
                cmd.q_fin  = 1'b1;
                cnt_next   = 7'd0;
                state_next = S_VDIV;
            end
            S_VDIV:
            begin
                if (!st.n_gt1)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    if (cnt_reg == 7'd0)
                    begin
                        cmd.vdiv_start = 1'b1;
                    end
                    else
                    begin
                        cmd.vdiv_step = 1'b1;
                    end
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd64)
                    begin
                        cnt_next   = 7'd0;
                        state_next = S_SQRT;
                    end
                end
            end
            S_SQRT:
            begin
                if (cnt_reg == 7'd0)
                begin
                    cmd.sqrt_start = 1'b1;
                end
                else
                begin
                    cmd.sqrt_step = 1'b1;
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd32)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!ov_next)
                begin
                    cmd.res_fin = 1'b1;
                    ov_next     = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// ===== src/psrs_dp.sv =====
module psrs_dp
#(
    parameter int SLOT_COUNT  = psrs_pkg::SLOT_COUNT_DEF,
    parameter int SAMPLE_BITS = psrs_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  psrs_pkg::in_item_t  in_data,
    input  psrs_pkg::cmd_t      cmd,
    output psrs_pkg::stat_t     st,
    output psrs_pkg::out_item_t out_data
);
    import psrs_pkg::*;

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int EW = 32 + 32 + 64 + 32 + 1;

    // entry: valid epoch, count, mean, q, max
    logic [EW-1:0] mem [SLOT_COUNT];
    logic [EW-1:0] rd_reg;

    logic          epoch_reg;
    logic          cmdc_reg;
    logic [7:0]    slot_reg;
    logic [31:0]   x_reg;
    logic [AW:0]   clr_reg;

    logic [31:0]   n_reg, mx_reg, mold_reg, mnew_reg, a_reg, b_reg;
    logic          up_reg;
    logic [63:0]   q_reg, prod_reg;

    logic [63:0]   rem_reg;
    logic [63:0]   quo_reg;
    logic [63:0]   dvs_reg;
    logic [6:0]    dcnt_reg;

    logic [63:0]   sv_reg, sres_reg, sbit_reg;

    logic [AW-1:0] addr;
    logic          rd_ok;
    logic [31:0]   r_cnt, r_mean, r_max;
    logic [63:0]   r_q;
    logic [31:0]   smask;
    logic [32:0]   dsum;
    logic [47:0]   pp;

    assign smask  = (SAMPLE_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << SAMPLE_BITS) - 32'd1);
    assign addr   = AW'(slot_reg);
    assign rd_ok  = (rd_reg[EW-1] == epoch_reg);
    assign r_cnt  = rd_ok ? rd_reg[159:128] : '0;
    assign r_mean = rd_ok ? rd_reg[127:96] : '0;
    assign r_q    = rd_ok ? rd_reg[95:32] : '0;
    assign r_max  = rd_ok ? rd_reg[31:0] : '0;

    assign st.is_clear = (cmdc_reg == CMD_CLEAR);
    assign st.in_range = ({24'd0, slot_reg} < 32'(SLOT_COUNT));
    assign st.clr_last = (clr_reg == (AW+1)'(SLOT_COUNT - 1));
    assign st.n_gt1    = (n_reg > 32'd1);

    // mean step dividend, rounded to nearest
    assign dsum = {1'b0, a_reg} + {2'b0, n_reg[31:1]};

    // 32x16 partial product
    assign pp = a_reg * ((dcnt_reg == 7'd0) ? b_reg[15:0] : b_reg[31:16]);

    // divider step (restoring, 64-bit dividend, 32-bit divisor)
    logic [64:0] trial;
    assign trial = {rem_reg, quo_reg[63]} - {1'b0, dvs_reg};

    // sqrt step
    logic [63:0] s_sum;
    assign s_sum = sres_reg + sbit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= 1'b1;
        end
        else if (cmd.clr_start)
        begin
            epoch_reg <= ~epoch_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmdc_reg <= in_data.command;
            slot_reg <= in_data.slot;
            x_reg    <= in_data.sample & smask;
        end
        if (cmd.clr_start)
        begin
            clr_reg <= '0;
        end
        if (cmd.clr_step)
        begin
            mem[clr_reg[AW-1:0]] <= {epoch_reg, {(EW-1){1'b0}}};
            clr_reg <= clr_reg + 1'b1;
        end
        rd_reg <= mem[addr];
        if (cmd.upd)
        begin
            n_reg    <= (r_cnt == 32'hFFFF_FFFF) ? r_cnt : r_cnt + 32'd1;
            mx_reg   <= (x_reg > r_max) ? x_reg : r_max;
            mold_reg <= r_mean;
            q_reg    <= r_q;
            up_reg   <= (x_reg >= r_mean);
            a_reg    <= (x_reg >= r_mean) ? x_reg - r_mean : r_mean - x_reg;
        end
        if (cmd.div_start)
        begin
            // top dividend bit preloaded into the remainder, 32 steps for the rest
            rem_reg  <= {63'd0, dsum[32]};
            quo_reg  <= {dsum[31:0], 32'd0};
            dvs_reg  <= {32'd0, n_reg};
            dcnt_reg <= 7'd32;
        end
        if (cmd.vdiv_start)
        begin
            rem_reg  <= '0;
            quo_reg  <= q_reg;
            dvs_reg  <= {32'd0, n_reg - 32'd1};
            dcnt_reg <= 7'd64;
        end
        if ((cmd.div_step || cmd.vdiv_step) && dcnt_reg != 7'd0)
        begin
            if (!trial[64])
            begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[62:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 7'd1;
        end
        if (cmd.mean_fin)
        begin
            logic [31:0] mn;
            mn = up_reg ? mold_reg + quo_reg[31:0] : mold_reg - quo_reg[31:0];
            mnew_reg <= mn;
            b_reg    <= (x_reg >= mn) ? x_reg - mn : mn - x_reg;
            prod_reg <= '0;
            dcnt_reg <= 7'd0;
        end
        if (cmd.mul_step)
        begin
            // two 32x16 partial products
            if (dcnt_reg == 7'd0)
            begin
                prod_reg <= {16'd0, pp};
            end
            else
            begin
                prod_reg <= prod_reg + {pp, 16'd0};
            end
            dcnt_reg <= dcnt_reg + 7'd1;
        end
        if (cmd.q_fin)
        begin
            logic [64:0] qs;
            qs = {1'b0, q_reg} + {1'b0, prod_reg};
            q_reg <= qs[64] ? 64'hFFFF_FFFF_FFFF_FFFF : qs[63:0];
            mem[addr] <= {epoch_reg, n_reg, mnew_reg,
                          (qs[64] ? 64'hFFFF_FFFF_FFFF_FFFF : qs[63:0]), mx_reg};
            sres_reg <= '0;
        end
        if (cmd.sqrt_start)
        begin
            sv_reg   <= quo_reg;
            sres_reg <= '0;
            sbit_reg <= 64'd1 << 62;
        end
        if (cmd.sqrt_step && sbit_reg != 64'd0)
        begin
            if (sv_reg >= s_sum)
            begin
                sv_reg   <= sv_reg - s_sum;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
            begin
                sres_reg <= sres_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
        if (cmd.res_fin)
        begin
            out_data.slot_out     <= slot_reg;
            out_data.current_time <= x_reg;
            out_data.mean_time    <= mnew_reg;
            out_data.std_dev      <= (n_reg > 32'd1) ? sres_reg[31:0] : 32'd0;
            out_data.max_time     <= mx_reg;
            out_data.sample_count <= n_reg;
        end
    end

endmodule

// ===== src/per_slot_running_stats_top.sv =====
// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | in_data  (in_item_t)
// output  | out_valid | out_stall | out_data (out_item_t)
// A sample passes from acceptance to out_valid through the 32-step mean divider, a
// two-partial-product multiply, the 64-step variance divider and the 32-step square
// root, the last two skipped while the count is at most one; the input stalls until then.
// A clear sweeps the memory, one slot a cycle, and holds off the input until it is done.
// After reset the memory is swept clear once, no input taken.
// Output register holds the result while out_stall is high; the next result waits.
module per_slot_running_stats_top
#(
    parameter int SLOT_COUNT  = psrs_pkg::SLOT_COUNT_DEF,
    parameter int SAMPLE_BITS = psrs_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  psrs_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output psrs_pkg::out_item_t out_data
);
    import psrs_pkg::*;

    cmd_t  cmd;
    stat_t st;

    psrs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    psrs_dp #(.SLOT_COUNT(SLOT_COUNT), .SAMPLE_BITS(SAMPLE_BITS)) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .st       (st),
        .out_data (out_data)
    );

endmodule

// ===== tb/per_slot_running_stats_top_tb.sv =====
`timescale 1ns / 1ps

module per_slot_running_stats_top_tb;
    import psrs_pkg::*;

    localparam int NSLOT    = SLOT_COUNT_DEF;
    localparam int N_RANDOM = 1525;
    localparam int WDOG_LIM = 20000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    per_slot_running_stats_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow statistics
    logic [31:0] st_count [NSLOT];
    logic [31:0] st_mean  [NSLOT];
    logic [63:0] st_sqdev [NSLOT];
    logic [31:0] st_max   [NSLOT];

    out_item_t exp_results[$];
    out_item_t exp_fixed[$];
    bit        exp_is_fixed[$];
    int        n_err;
    int        n_samples;
    int        n_clears;
    int        n_results;
    int        idle_cycles;
    bit        hold_off;
    bit        no_idle;

    typedef struct {
        in_item_t item;
        bit       fixed;
        out_item_t res;
    } dir_row_t;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic clear_stats();
        for (int i = 0; i < NSLOT; i++)
        begin
            st_count[i] = 0;
            st_mean[i]  = 0;
            st_sqdev[i] = 0;
            st_max[i]   = 0;
        end
    endtask

    // returns 1 when a result is produced
    task automatic update_stats(input in_item_t it, output bit has_res, output out_item_t r);
        logic [63:0] n, x, mo, mn, a, b, stp, prod, q, sd;
        bit          up;
        int          s;
        has_res = 0;
        r = '0;
        if (it.command == CMD_CLEAR)
        begin
            clear_stats();
            return;
        end
        s = int'(it.slot);
        if (s >= NSLOT)
            return;
        x = {32'd0, it.sample};
        n = {32'd0, st_count[s]};
        if (n < 64'hFFFF_FFFF)
            n = n + 1;
        st_count[s] = n[31:0];
        if (x[31:0] > st_max[s])
            st_max[s] = x[31:0];
        mo = {32'd0, st_mean[s]};
        up = x >= mo;
        a = up ? x - mo : mo - x;
        stp = (a + (n >> 1)) / n;
        mn = up ? mo + stp : mo - stp;
        st_mean[s] = mn[31:0];
        b = (x >= mn) ? x - mn : mn - x;
        prod = a * b;
        q = st_sqdev[s];
        q = (q > ~prod) ? 64'hFFFF_FFFF_FFFF_FFFF : q + prod;
        st_sqdev[s] = q;
        sd = 0;
        if (n > 1)
            sd = int_sqrt(q / (n - 1));
        r.slot_out     = it.slot;
        r.current_time = x[31:0];
        r.mean_time    = mn[31:0];
        r.std_dev      = sd[31:0];
        r.max_time     = st_max[s];
        r.sample_count = n[31:0];
        has_res = 1;
    endtask

    task automatic send_item(input in_item_t it, input bit fixed, input out_item_t fres);
        bit        has_res;
        out_item_t r;
        while (!no_idle && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        update_stats(it, has_res, r);
        if (it.command == CMD_CLEAR)
            n_clears++;
        if (has_res)
        begin
            n_samples++;
            exp_results.push_back(r);
            exp_is_fixed.push_back(fixed);
            exp_fixed.push_back(fres);
        end
    endtask

    function automatic in_item_t mk(input logic c, input logic [7:0] s, input logic [31:0] x);
        in_item_t it;
        it.command = c;
        it.slot    = s;
        it.sample  = x;
        return it;
    endfunction

    function automatic out_item_t mo_res(input logic [7:0] s, input logic [31:0] x,
                                         input logic [31:0] m, input logic [31:0] sd,
                                         input logic [31:0] mx, input logic [31:0] n);
        out_item_t r;
        r.slot_out     = s;
        r.current_time = x;
        r.mean_time    = m;
        r.std_dev      = sd;
        r.max_time     = mx;
        r.sample_count = n;
        return r;
    endfunction

    // Receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= !no_idle && ($urandom_range(99) < 23);
    end

    // Result checker
    always @(posedge clk)
    begin
        out_item_t e;
        out_item_t fe;
        bit        fx;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (exp_results.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: unexpected result %p", out_data);
            end
            else
            begin
                e  = exp_results.pop_front();
                fx = exp_is_fixed.pop_front();
                fe = exp_fixed.pop_front();
                if (fx && fe != e)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: table row %p disagrees with predictor %p", fe, e);
                end
                if (out_data.slot_out != e.slot_out
                    || out_data.current_time != e.current_time
                    || out_data.mean_time != e.mean_time
                    || out_data.std_dev != e.std_dev
                    || out_data.max_time != e.max_time
                    || out_data.sample_count != e.sample_count)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: result mismatch exp %p got %p", e, out_data);
                end
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering
    initial
    begin
        int cnt;
        hold_off = 1'b0;
        wait (n_samples >= 300);
        hold_off = 1'b1;
        cnt = 0;
        while (cnt < 3000)
        begin
            @(posedge clk);
            cnt++;
        end
        hold_off = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= WDOG_LIM)
        begin
            $display("ERROR: watchdog timeout");
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        dir_row_t  rows[$];
        dir_row_t  d;
        in_item_t  it;
        out_item_t z;
        int        hot_slot;
        int        tail;
        z = '0;
        n_err = 0;
        n_samples = 0;
        n_clears = 0;
        n_results = 0;
        idle_cycles = 0;
        no_idle = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        clear_stats();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        d.fixed = 1; d.item = mk(CMD_SAMPLE, 8'd0, 32'd0);
        d.res = mo_res(8'd0, 0, 0, 0, 0, 1); rows.push_back(d);
        d.item = mk(CMD_SAMPLE, 8'd255, 32'hFFFF_FFFF);
        d.res = mo_res(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1);
        rows.push_back(d);
        d.fixed = 0;
        d.item = mk(CMD_SAMPLE, 8'd255, 32'd0); rows.push_back(d);
        d.item = mk(CMD_SAMPLE, 8'd255, 32'hFFFF_FFFF); rows.push_back(d);
        d.item = mk(CMD_SAMPLE, 8'd255, 32'd0); rows.push_back(d);
        d.item = mk(CMD_SAMPLE, 8'd0, 32'hFFFF_FFFF); rows.push_back(d);
        d.item = mk(CMD_SAMPLE, 8'd0, 32'h5555_5555); rows.push_back(d);
        d.item = mk(CMD_SAMPLE, 8'd0, 32'hAAAA_AAAA); rows.push_back(d);
        d.item = mk(CMD_SAMPLE, 8'd1, 32'h0000_0100); rows.push_back(d);
        d.item = mk(CMD_SAMPLE, 8'd1, 32'h0000_0101); rows.push_back(d);
        d.item = mk(CMD_SAMPLE, 8'd1, 32'h0000_0100); rows.push_back(d);
        d.item = mk(CMD_SAMPLE, 8'd1, 32'h0000_0102); rows.push_back(d);
        d.item = mk(CMD_SAMPLE, 8'hAA, 32'h8000_0000); rows.push_back(d);
        d.item = mk(CMD_SAMPLE, 8'h55, 32'h0000_0001); rows.push_back(d);
        d.item = mk(CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF); rows.push_back(d);
        d.fixed = 1;
        d.item = mk(CMD_SAMPLE, 8'd255, 32'd7);
        d.res = mo_res(8'd255, 7, 7, 0, 7, 1); rows.push_back(d);
        d.item = mk(CMD_SAMPLE, 8'd0, 32'd9);
        d.res = mo_res(8'd0, 9, 9, 0, 9, 1); rows.push_back(d);
        d.fixed = 0;
        d.item = mk(CMD_SAMPLE, 8'd0, 32'd1); rows.push_back(d);
        d.item = mk(CMD_CLEAR, 8'd0, 32'd0); rows.push_back(d);
        d.item = mk(CMD_SAMPLE, 8'd0, 32'd3); rows.push_back(d);

        foreach (rows[i])
            send_item(rows[i].item, rows[i].fixed, rows[i].res);

        hot_slot = $urandom_range(255);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            no_idle = (i >= 600 && i < 800);
            if ($urandom_range(199) == 0)
                it = mk(CMD_CLEAR, 8'($urandom_range(255)), $urandom);
            else
            begin
                it.command = CMD_SAMPLE;
                case ($urandom_range(3))
                    0: it.slot = 8'($urandom_range(255));
                    1: it.slot = 8'(hot_slot);
                    default: it.slot = 8'($urandom_range(7));
                endcase
                case ($urandom_range(5))
                    0: it.sample = $urandom;
                    1: it.sample = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
                    2: it.sample = 32'hFFFF_0000 | $urandom_range(16'hFFFF);
                    default: it.sample = 32'h0001_0000 + $urandom_range(4095);
                endcase
            end
            send_item(it, 1'b0, z);
        end
        in_valid <= 1'b0;
        no_idle = 0;

        while (exp_results.size() != 0)
            @(posedge clk);
        tail = 0;
        while (tail < 400)
        begin
            @(posedge clk);
            tail++;
        end
        if (exp_results.size() != 0)
            n_err++;

        $display("Run covered %0d samples, %0d clears, %0d results checked, %0d mismatches.",
                 n_samples, n_clears, n_results, n_err);
        if (n_err == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
